@@ rtl/rfo_pkg.sv @@
// rfo_pkg: shared types and constants for the ring FIFO with overwrite.
// No dependencies.
package rfo_pkg;

	localparam int FIELD_BITS = 64;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_PEEK  = 2'd2,
		OP_FLUSH = 2'd3
	} rfo_op_t;

	typedef struct packed {
		logic shift;
		logic load;
		logic clear;
	} rfo_cell_ctrl_t;

endpackage

@@ rtl/rfo_cell.sv @@
// rfo_cell: one storage cell of the FIFO chain; holds one word, clears it or loads a
// new word, and otherwise takes its neighbor's word on a shift. Depends on rfo_pkg.
module rfo_cell #(
	parameter int ENTRY_BITS = 64
) (
	input  logic                        clk,
	input  rfo_pkg::rfo_cell_ctrl_t     ctrl,
	input  logic [ENTRY_BITS-1:0]       next_data,
	input  logic [ENTRY_BITS-1:0]       load_data,
	output logic [ENTRY_BITS-1:0]       data_q
);
	import rfo_pkg::*;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			data_q <= '0;
		end else if (ctrl.load) begin
			data_q <= load_data;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

endmodule

@@ rtl/ring_fifo_with_overwrite_unit.sv @@
// ring_fifo_with_overwrite_unit: top level, a chain of rfo_cell holding the
// FIFO words oldest first, plus count and result registers. Depends on rfo_pkg, rfo_cell.
//
//  channel   handshake        fields
//  command   start / busy     operation, push_data, overwrite_if_full
//  result    done (strobe)    status, read_data, entry_count, is_full_now, dropped_oldest
//
// One command per cycle; busy stays low. The result strobes on done in the
// cycle after the command is taken. Every word sits in a cell at its age
// position, so pop and overwrite shift the whole chain by one cell together.
// Reset empties the FIFO; the receiver cannot stall results.
module ring_fifo_with_overwrite_unit #(
	parameter int DEPTH      = 16,
	parameter int ENTRY_BITS = 64,
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        operation,
	input  logic [rfo_pkg::FIELD_BITS-1:0]    push_data,
	input  logic                              overwrite_if_full,
	output logic                              done,
	output logic                              status,
	output logic [rfo_pkg::FIELD_BITS-1:0]    read_data,
	output logic [CNT_W-1:0]                  entry_count,
	output logic                              is_full_now,
	output logic                              dropped_oldest
);
	import rfo_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic                  acc;
	logic                  full;
	logic                  empty;
	logic                  is_push, is_pop, is_peek, is_flush;
	logic                  do_shift, do_write, do_over;
	logic                  res_status;
	logic                  res_read;
	rfo_op_t               op;
	logic [ENTRY_BITS-1:0] wdata;
	logic [ENTRY_BITS-1:0] cell_data [DEPTH+1];
	rfo_cell_ctrl_t        cell_ctrl [DEPTH];

	logic                  done_q;
	logic                  status_q;
	logic [FIELD_BITS-1:0] read_data_q;
	logic                  dropped_q;

	assign busy  = 1'b0;
	assign acc   = start & ~busy;
	assign op    = rfo_op_t'(operation);
	assign wdata = push_data[ENTRY_BITS-1:0];
	assign full  = (count_q == DEPTH_CNT);
	assign empty = (count_q == '0);

	always_comb begin
		is_push  = 1'b0;
		is_pop   = 1'b0;
		is_peek  = 1'b0;
		is_flush = 1'b0;
		unique case (op)
			OP_PUSH:  is_push  = 1'b1;
			OP_POP:   is_pop   = 1'b1;
			OP_PEEK:  is_peek  = 1'b1;
			OP_FLUSH: is_flush = 1'b1;
			default:  is_flush = 1'b0;
		endcase
	end

	always_comb begin
		do_over    = acc & is_push & full & overwrite_if_full;
		do_write   = acc & is_push & ~full;
		do_shift   = do_over | (acc & is_pop & ~empty);
		res_status = (is_push & full & ~overwrite_if_full) | ((is_pop | is_peek) & empty);
		res_read   = (is_pop | is_peek) & ~empty;
		count_nxt  = count_q;
		if (acc) begin
			if (is_flush) begin
				count_nxt = '0;
			end else if (do_write) begin
				count_nxt = count_q + CNT_W'(1);
			end else if (is_pop & ~empty) begin
				count_nxt = count_q - CNT_W'(1);
			end
		end
	end

	assign cell_data[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		always_comb begin
			cell_ctrl[i].shift = do_shift;
			cell_ctrl[i].clear = acc & is_flush;
			cell_ctrl[i].load  = (do_write & (count_q == IDX)) | (do_over & (i == DEPTH - 1));
		end
		rfo_cell #(
			.ENTRY_BITS(ENTRY_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[i]),
			.next_data(cell_data[i+1]),
			.load_data(wdata),
			.data_q   (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q    <= res_status;
			read_data_q <= res_read ? FIELD_BITS'(cell_data[0]) : '0;
			dropped_q   <= do_over;
		end
	end

	logic [CNT_W-1:0] count_res_q;
	always_ff @(posedge clk) begin
		if (acc) begin
			count_res_q <= count_nxt;
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign read_data      = read_data_q;
	assign entry_count    = count_res_q;
	assign is_full_now    = (count_res_q == DEPTH_CNT);
	assign dropped_oldest = dropped_q;

endmodule

@@ bench/tb_ring_fifo_with_overwrite_unit.sv @@
// tb_ring_fifo_with_overwrite_unit: self-checking bench for the ring FIFO with overwrite.
// Directed command table, then random push/pop/peek/flush bursts vs a local FIFO mirror.
// Depends on rfo_pkg and ring_fifo_with_overwrite_unit.
module tb_ring_fifo_with_overwrite_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rfo_pkg::*;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int RANDOM_WORDS = 900;
	localparam int IDLE_LIMIT = 2000;
	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic             status;
		logic [63:0]      read_data;
		logic [CNT_W-1:0] entry_count;
		logic             is_full_now;
		logic             dropped_oldest;
	} fifo_result_t;

	typedef struct {
		rfo_op_t      op;
		logic [63:0]  data;
		logic         ow;
		int           reps;
		logic         fixed;
		fifo_result_t res;
	} cmd_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] operation;
	logic [63:0] push_data;
	logic overwrite_if_full;
	logic done;
	logic status;
	logic [63:0] read_data;
	logic [CNT_W-1:0] entry_count;
	logic is_full_now;
	logic dropped_oldest;

	// typed-in expectation travels with the word
	logic fixed_valid;
	fifo_result_t fixed_result;

	logic [63:0] mirror_store [DEPTH];
	int unsigned wr_ptr, rd_ptr, fill;
	fifo_result_t pending_results [$];

	int mismatches, idle_cycles;
	int n_words, n_checked, n_dropped, n_full_reject, n_empty_err, n_flush;

	cmd_row_t cmd_table [15] = '{
		'{OP_POP,   64'd0, 1'b0, 1, 1'b1, '{1'b1, 64'd0, 5'd0, 1'b0, 1'b0}},
		'{OP_PEEK,  ONES, 1'b1, 1, 1'b1, '{1'b1, 64'd0, 5'd0, 1'b0, 1'b0}},
		'{OP_PUSH,  ONES, 1'b0, 1, 1'b1, '{1'b0, 64'd0, 5'd1, 1'b0, 1'b0}},
		'{OP_PEEK,  64'd0, 1'b0, 1, 1'b1, '{1'b0, ONES, 5'd1, 1'b0, 1'b0}},
		'{OP_POP,   64'd0, 1'b0, 1, 1'b1, '{1'b0, ONES, 5'd0, 1'b0, 1'b0}},
		'{OP_PUSH,  64'd0, 1'b1, 1, 1'b1, '{1'b0, 64'd0, 5'd1, 1'b0, 1'b0}},
		'{OP_PUSH,  64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 15, 1'b0, '0},
		'{OP_PUSH,  64'h1234, 1'b0, 1, 1'b1, '{1'b1, 64'd0, 5'd16, 1'b1, 1'b0}},
		'{OP_PUSH,  64'h5A5A_5A5A_5A5A_5A5A, 1'b1, 1, 1'b1, '{1'b0, 64'd0, 5'd16, 1'b1, 1'b1}},
		'{OP_PEEK,  64'd0, 1'b0, 1, 1'b0, '0},
		'{OP_POP,   64'd0, 1'b0, 2, 1'b0, '0},
		'{OP_PUSH,  64'h8000_0000_0000_0001, 1'b0, 2, 1'b0, '0},
		'{OP_FLUSH, ONES, 1'b1, 1, 1'b1, '{1'b0, 64'd0, 5'd0, 1'b0, 1'b0}},
		'{OP_PEEK,  64'd0, 1'b0, 1, 1'b1, '{1'b1, 64'd0, 5'd0, 1'b0, 1'b0}},
		'{OP_PUSH,  ONES, 1'b1, 1, 1'b1, '{1'b0, 64'd0, 5'd1, 1'b0, 1'b0}}
	};

	ring_fifo_with_overwrite_unit #(
		.DEPTH(DEPTH),
		.ENTRY_BITS(64)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.push_data(push_data),
		.overwrite_if_full(overwrite_if_full),
		.done(done),
		.status(status),
		.read_data(read_data),
		.entry_count(entry_count),
		.is_full_now(is_full_now),
		.dropped_oldest(dropped_oldest)
	);

	always #5 clk = ~clk;

	function automatic fifo_result_t predict_fifo_result(rfo_op_t op, logic [63:0] data,
			logic ow);
		fifo_result_t r;
		r = '0;
		case (op)
			OP_PUSH: begin
				if (fill == DEPTH && !ow) begin
					r.status = 1'b1;
				end else begin
					if (fill == DEPTH) begin
						rd_ptr = (rd_ptr + 1) % DEPTH;
						fill = fill - 1;
						r.dropped_oldest = 1'b1;
					end
					mirror_store[wr_ptr] = data;
					wr_ptr = (wr_ptr + 1) % DEPTH;
					fill = fill + 1;
				end
			end
			OP_POP, OP_PEEK: begin
				if (fill == 0) begin
					r.status = 1'b1;
				end else begin
					r.read_data = mirror_store[rd_ptr];
					if (op == OP_POP) begin
						rd_ptr = (rd_ptr + 1) % DEPTH;
						fill = fill - 1;
					end
				end
			end
			default: begin
				for (int i = 0; i < DEPTH; i++) mirror_store[i] = '0;
				wr_ptr = 0;
				rd_ptr = 0;
				fill = 0;
			end
		endcase
		r.entry_count = fill[CNT_W-1:0];
		r.is_full_now = (fill == DEPTH);
		return r;
	endfunction

	task automatic report_mismatch(string what, fifo_result_t want, fifo_result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("[%0t] %s: exp st=%0b rd=%h cnt=%0d full=%0b drop=%0b",
				$realtime, what, want.status, want.read_data, want.entry_count,
				want.is_full_now, want.dropped_oldest);
			$display("    got st=%0b rd=%h cnt=%0d full=%0b drop=%0b",
				got.status, got.read_data, got.entry_count, got.is_full_now,
				got.dropped_oldest);
		end
	endtask

	// result check first, then the word accepted at this edge
	always @(posedge clk) begin
		fifo_result_t want, got;
		if (arst_n) begin
			idle_cycles++;
			if (done) begin
				idle_cycles = 0;
				n_checked++;
				got = '{status, read_data, entry_count, is_full_now, dropped_oldest};
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (got.status !== want.status || got.read_data !== want.read_data ||
							got.entry_count !== want.entry_count ||
							got.is_full_now !== want.is_full_now ||
							got.dropped_oldest !== want.dropped_oldest)
						report_mismatch("field mismatch", want, got);
				end
			end
			if (start && !busy) begin
				idle_cycles = 0;
				n_words++;
				want = predict_fifo_result(rfo_op_t'(operation), push_data, overwrite_if_full);
				if (want.dropped_oldest) n_dropped++;
				if (want.status && rfo_op_t'(operation) == OP_PUSH) n_full_reject++;
				if (want.status && rfo_op_t'(operation) != OP_PUSH) n_empty_err++;
				if (rfo_op_t'(operation) == OP_FLUSH) n_flush++;
				pending_results.push_back(fixed_valid ? fixed_result : want);
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("ring_fifo_with_overwrite_unit: mismatch");
				$finish;
			end
		end
	end

	task automatic send_word(rfo_op_t op, logic [63:0] data, logic ow, int gap, logic fixed,
			fifo_result_t res);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		push_data <= data;
		overwrite_if_full <= ow;
		fixed_valid <= fixed;
		fixed_result <= res;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		rfo_op_t op;
		logic [63:0] data;
		int pick, push_bias;
		bit gaps_on;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_PUSH;
		push_data = '0;
		overwrite_if_full = 1'b0;
		fixed_valid = 1'b0;
		fixed_result = '0;
		for (int i = 0; i < DEPTH; i++) mirror_store[i] = '0;
		wr_ptr = 0;
		rd_ptr = 0;
		fill = 0;
		mismatches = 0;
		idle_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (cmd_table[r])
			repeat (cmd_table[r].reps)
				send_word(cmd_table[r].op, cmd_table[r].data, cmd_table[r].ow,
					$urandom_range(0, 8), cmd_table[r].fixed, cmd_table[r].res);

		// bursts lean toward filling or draining so full and empty both get exercised
		push_bias = 60;
		gaps_on = 1'b1;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 40 == 0) begin
				push_bias = $urandom_range(20, 90);
				gaps_on = ($urandom_range(0, 2) != 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 3)
				op = OP_FLUSH;
			else if (pick < push_bias)
				op = OP_PUSH;
			else if (pick < push_bias + (100 - push_bias) / 4)
				op = OP_PEEK;
			else
				op = OP_POP;
			case ($urandom_range(0, 7))
				0: data = '0;
				1: data = ONES;
				default: data = {$urandom, $urandom};
			endcase
			send_word(op, data, 1'($urandom_range(0, 1)), gaps_on ? $urandom_range(0, 8) : 0,
				1'b0, '0);
		end
		start <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		$display("words %0d, results checked %0d, flushes %0d, oldest dropped %0d",
			n_words, n_checked, n_flush, n_dropped);
		$display("full pushes refused %0d, empty pop/peek %0d, mismatches %0d",
			n_full_reject, n_empty_err, mismatches);
		if (mismatches == 0)
			$display("ring_fifo_with_overwrite_unit: match");
		else
			$display("ring_fifo_with_overwrite_unit: mismatch");
		$finish;
	end
endmodule
